// File: hdl/cjknf_pkg.sv
// Package for the CJK numeral formatter: widths, style codes and glyph tables.
// No dependencies.
`timescale 1ns / 1ps
package cjknf_pkg;

    localparam int MaxGroups = 3;
    localparam int ValueW    = 32;
    localparam int CpW       = 16;
    localparam int DigitsN   = 4 * MaxGroups;
    localparam int MaxOut    = 20;
    localparam int StyleW    = 3;

    typedef enum logic [StyleW-1:0] {
        STY_SIMP_INF  = 3'd0,
        STY_SIMP_FRM  = 3'd1,
        STY_TRAD_INF  = 3'd2,
        STY_TRAD_FRM  = 3'd3,
        STY_JP_INF    = 3'd4,
        STY_JP_FRM    = 3'd5
    } style_t;

    // 10^(4*MaxGroups) - 1, limited to the 32-bit range, saturation cap
    function automatic logic [ValueW-1:0] cap_value();
        logic [63:0] c;
        c = 64'd1;
        for (int i = 0; i < MaxGroups; i++)
            c = c * 64'd10000;
        c = c - 64'd1;
        if (c > 64'hFFFF_FFFF)
            c = 64'hFFFF_FFFF;
        return c[ValueW-1:0];
    endfunction

    function automatic logic [CpW-1:0] digit_cp(input logic [2:0] s, input logic [3:0] d);
        logic [CpW-1:0] r;
        r = 16'h96F6;
        unique case (d)
            4'd0: r = (s == STY_JP_INF) ? 16'h3007 : 16'h96F6;
            4'd1: r = (s == STY_SIMP_FRM || s == STY_TRAD_FRM) ? 16'h58F9 :
                      (s == STY_JP_FRM) ? 16'h58F1 : 16'h4E00;
            4'd2: r = (s == STY_SIMP_FRM) ? 16'h8D30 : (s == STY_TRAD_FRM) ? 16'h8CB3 :
                      (s == STY_JP_FRM) ? 16'h5F10 : 16'h4E8C;
            4'd3: r = (s == STY_SIMP_FRM) ? 16'h53C1 : (s == STY_TRAD_FRM) ? 16'h53C3 :
                      (s == STY_JP_FRM) ? 16'h53C2 : 16'h4E09;
            4'd4: r = (s == STY_SIMP_FRM || s == STY_TRAD_FRM) ? 16'h8086 : 16'h56DB;
            4'd5: r = (s == STY_SIMP_FRM || s == STY_TRAD_FRM || s == STY_JP_FRM) ?
                      16'h4F0D : 16'h4E94;
            4'd6: r = (s == STY_SIMP_FRM) ? 16'h9646 : (s == STY_TRAD_FRM) ? 16'h9678 :
                      16'h516D;
            4'd7: r = (s == STY_SIMP_FRM || s == STY_TRAD_FRM) ? 16'h67D2 : 16'h4E03;
            4'd8: r = (s == STY_SIMP_FRM || s == STY_TRAD_FRM) ? 16'h634C : 16'h516B;
            4'd9: r = (s == STY_SIMP_FRM || s == STY_TRAD_FRM) ? 16'h7396 : 16'h4E5D;
            default: r = 16'h96F6;
        endcase
        return r;
    endfunction

    // place 1..3 = ten, hundred, thousand
    function automatic logic [CpW-1:0] dmark_cp(input logic [2:0] s, input logic [1:0] p);
        logic frm;
        logic [CpW-1:0] r;
        frm = (s == STY_SIMP_FRM || s == STY_TRAD_FRM || s == STY_JP_FRM);
        unique case (p)
            2'd1: r = frm ? 16'h62FE : 16'h5341;
            2'd2: r = (s == STY_SIMP_FRM || s == STY_TRAD_FRM) ? 16'h4F70 : 16'h767E;
            2'd3: r = (s == STY_JP_FRM) ? 16'h9621 : frm ? 16'h4EDF : 16'h5343;
            default: r = 16'h5341;
        endcase
        return r;
    endfunction

    // group 1..3
    function automatic logic [CpW-1:0] gmark_cp(input logic [2:0] s, input logic [1:0] g);
        logic simp;
        logic [CpW-1:0] r;
        simp = (s == STY_SIMP_INF || s == STY_SIMP_FRM);
        unique case (g)
            2'd1: r = (simp || s == STY_JP_INF) ? 16'h4E07 : 16'h842C;
            2'd2: r = simp ? 16'h4EBF : 16'h5104;
            2'd3: r = simp ? 16'h4E07 : 16'h5146;
            default: r = 16'h4E07;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/cjknf_bcd.sv
// Bit-serial binary to BCD converter (double dabble, one bit per cycle).
// Depends on cjknf_pkg.
`timescale 1ns / 1ps
module cjknf_bcd (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [cjknf_pkg::ValueW-1:0]           bin,
    output logic                                   done,
    output logic [4*cjknf_pkg::DigitsN-1:0]        bcd
);
    import cjknf_pkg::*;

    localparam int CntW = $clog2(ValueW + 1);

    logic [ValueW-1:0]    sh_reg, sh_next;
    logic [4*DigitsN-1:0] bcd_reg, bcd_next, adj;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic                 busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        for (int i = 0; i < DigitsN; i++)
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] > 4'd4) ? bcd_reg[4*i +: 4] + 4'd3
                                                       : bcd_reg[4*i +: 4];
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = bin;
            bcd_next  = '0;
            cnt_next  = CntW'(ValueW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[4*DigitsN-2:0], sh_reg[ValueW-1]};
            sh_next  = {sh_reg[ValueW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

    property p_done_single;
        @(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg;
    endproperty
    a_done_single: assert property (p_done_single) else $error("bcd done held");

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) $rose(done_reg) |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("bcd done w/o busy");

    property p_busy_drops;
        @(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg;
    endproperty
    a_busy_drops: assert property (p_busy_drops) else $error("bcd busy after done");
endmodule

// File: hdl/cjk_numeral_formatter.sv
// CJK numeral formatter top level: input capture, BCD conversion, digit sequencer.
// Depends on cjknf_pkg and cjknf_bcd.
// Flow: input capture, converter start, 32 bit-serial steps and load of the digits,
// then a scan of each digit position with its digit and group markers; each code point is held
// back one emission so tlast can be set, the last one leaves from the flush state after the scan.
// Throughput: one value at a time, taken only in idle; output stalls hold the scan.
// Reset: rst_n clears all registers and sets the style to simplified Chinese informal.
`timescale 1ns / 1ps
module cjk_numeral_formatter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_data,       // [2:0] style
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cjknf_pkg::ValueW-1:0]  s_axis_tdata,   // [31:0] value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cjknf_pkg::CpW-1:0]     m_axis_tdata,   // [15:0] code_point
    output logic                          m_axis_tlast    // last
);
    import cjknf_pkg::*;

    localparam int DigW  = $clog2(DigitsN);
    localparam int OutW  = $clog2(MaxOut + 1);
    localparam logic [ValueW-1:0] Cap = cap_value();

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_SCAN, S_DMARK, S_GMARK, S_GMARK2, S_FLUSH
    } st_t;

    st_t                  st_reg, st_next;
    logic [2:0]           style_reg, style_next;
    logic [2:0]           sty;
    logic                 bcd_start_reg, bcd_start_next, bcd_done;
    logic [4*DigitsN-1:0] bcd;
    logic [4*DigitsN-1:0] dig_reg, dig_next;      // digits, most significant in top nibble
    logic [DigW-1:0]      pos_reg, pos_next;      // current digit position, counts down
    logic                 started_reg, started_next;  // a nonzero digit has been seen
    logic [3:0]           prev_reg, prev_next;    // digit just above in this group
    logic                 gnz_reg, gnz_next;      // group has a nonzero digit so far
    logic [OutW-1:0]      n_reg, n_next;
    logic [CpW-1:0]       cp_reg, cp_next;
    logic                 ov_reg, ov_next, last_reg, last_next;
    logic [ValueW-1:0]    val_reg, val_next;
    logic                 hold_reg, hold_next;    // newest code point, not yet sent
    logic [CpW-1:0]       hold_cp_reg, hold_cp_next;

    // pending emission, built combinationally from current digit
    logic [3:0]  d;
    logic [1:0]  place;
    logic [1:0]  grp;
    logic        chinese, cn_inf, jp, jp_inf, drop, trailing, g1x;
    logic [15:0] grpdig;
    logic        emit;
    logic [CpW-1:0] emit_cp;
    logic        out_free;

    assign sty     = (style_reg > 3'd5) ? 3'd0 : style_reg;
    assign chinese = (sty <= 3'd3);
    assign cn_inf  = (sty == STY_SIMP_INF) || (sty == STY_TRAD_INF);
    assign jp      = !chinese;
    assign jp_inf  = (sty == STY_JP_INF);
    assign d       = dig_reg[4*DigitsN-1 -: 4];
    assign place   = pos_reg[1:0];
    assign grp     = 2'(pos_reg >> 2);
    assign out_free = !ov_reg || m_axis_tready;

    // digits of the current group: top nibbles of the shift line, aligned to place
    always_comb
    begin
        grpdig = dig_reg[4*DigitsN-1 -: 16] >> (4 * (3 - place));
        trailing = (grpdig[3:0] == 4'd0) && (place < 2'd1 || grpdig[7:4] == 4'd0)
                   && (place < 2'd2 || grpdig[11:8] == 4'd0)
                   && (place < 2'd3 || grpdig[15:12] == 4'd0);
        // tens digit of a group valued 10..19
        g1x = (place == 2'd1) && (d == 4'd1) && !gnz_reg;
        drop = 1'b0;
        if (cn_inf && g1x)
            drop = 1'b1;
        if (jp_inf && d == 4'd1 && place != 2'd0)
            drop = 1'b1;
        if (jp && d == 4'd0)
            drop = 1'b1;
        if (chinese && (trailing || (d == 4'd0 && place != 2'd3 && prev_reg == 4'd0)))
            drop = 1'b1;
        if (!started_reg && d == 4'd0)
            drop = 1'b1;
    end

    assign s_axis_tready = (st_reg == S_IDLE) && !ov_reg;
    assign cfg_ready     = (st_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = cp_reg;
    assign m_axis_tlast  = last_reg;

    cjknf_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start_reg),
        .bin   (val_reg),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    always_comb
    begin
        st_next        = st_reg;
        style_next     = style_reg;
        bcd_start_next = 1'b0;
        dig_next       = dig_reg;
        pos_next       = pos_reg;
        started_next   = started_reg;
        prev_next      = prev_reg;
        gnz_next       = gnz_reg;
        n_next         = n_reg;
        cp_next        = cp_reg;
        ov_next        = ov_reg && !m_axis_tready;
        last_next      = last_reg;
        val_next       = val_reg;
        hold_next      = hold_reg;
        hold_cp_next   = hold_cp_reg;
        emit           = 1'b0;
        emit_cp        = '0;
        if (cfg_valid && cfg_ready)
            style_next = cfg_data[2:0];
        unique case (st_reg)
            S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    val_next       = (s_axis_tdata > Cap) ? Cap : s_axis_tdata;
                    bcd_start_next = 1'b1;
                    n_next         = '0;
                    st_next        = S_CONV;
                end
            S_CONV:
                if (bcd_done)
                begin
                    dig_next     = bcd;
                    pos_next     = DigW'(DigitsN - 1);
                    started_next = 1'b0;
                    gnz_next     = 1'b0;
                    prev_next    = '0;
                    if (val_reg == '0)
                    begin
                        emit    = 1'b1;
                        emit_cp = digit_cp(sty, 4'd0);
                        st_next = S_FLUSH;
                    end
                    else
                        st_next = S_SCAN;
                end
            S_SCAN:
                if (out_free)
                begin
                    if (!drop)
                    begin
                        emit    = 1'b1;
                        emit_cp = digit_cp(sty, d);
                    end
                    if (d != 4'd0)
                    begin
                        started_next = 1'b1;
                        gnz_next     = 1'b1;
                    end
                    prev_next = d;
                    if (d != 4'd0 && place != 2'd0)
                        st_next = S_DMARK;
                    else
                        st_next = S_GMARK;
                end
            S_DMARK:
                if (out_free)
                begin
                    emit    = 1'b1;
                    emit_cp = dmark_cp(sty, place);
                    st_next = S_GMARK;
                end
            S_GMARK:
                if (out_free)
                begin
                    // end of a position: group marker when ones place of a nonzero group
                    if (place == 2'd0 && grp != 2'd0 && (gnz_reg || d != 4'd0))
                    begin
                        emit    = 1'b1;
                        emit_cp = gmark_cp(sty, grp);
                    end
                    if (place == 2'd0 && grp == 2'd3 && sty <= 3'd1 &&
                        (gnz_reg || d != 4'd0))
                        st_next = S_GMARK2;
                    else if (pos_reg == '0)
                        st_next = S_FLUSH;
                    else
                        st_next = S_SCAN;
                    dig_next = {dig_reg[4*DigitsN-5:0], 4'd0};
                    pos_next = pos_reg - 1'b1;
                    if (place == 2'd0)
                    begin
                        gnz_next  = 1'b0;
                        prev_next = '0;
                    end
                end
            S_GMARK2:
                if (out_free)
                begin
                    emit    = 1'b1;
                    emit_cp = 16'h4EBF;
                    st_next = S_SCAN;
                end
            S_FLUSH:
                if (out_free)
                begin
                    cp_next   = hold_cp_reg;
                    last_next = 1'b1;
                    ov_next   = 1'b1;
                    hold_next = 1'b0;
                    st_next   = S_IDLE;
                end
            default: st_next = S_IDLE;
        endcase
        // the held code point goes out once a newer one is known
        if (emit && n_reg < OutW'(MaxOut))
        begin
            n_next       = n_reg + 1'b1;
            hold_next    = 1'b1;
            hold_cp_next = emit_cp;
            if (hold_reg)
            begin
                cp_next   = hold_cp_reg;
                last_next = 1'b0;
                ov_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            style_reg     <= 3'd0;
            bcd_start_reg <= 1'b0;
            dig_reg       <= '0;
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            prev_reg      <= '0;
            gnz_reg       <= 1'b0;
            n_reg         <= '0;
            cp_reg        <= '0;
            ov_reg        <= 1'b0;
            last_reg      <= 1'b0;
            val_reg       <= '0;
            hold_reg      <= 1'b0;
            hold_cp_reg   <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            style_reg     <= style_next;
            bcd_start_reg <= bcd_start_next;
            dig_reg       <= dig_next;
            pos_reg       <= pos_next;
            started_reg   <= started_next;
            prev_reg      <= prev_next;
            gnz_reg       <= gnz_next;
            n_reg         <= n_next;
            cp_reg        <= cp_next;
            ov_reg        <= ov_next;
            last_reg      <= last_next;
            val_reg       <= val_next;
            hold_reg      <= hold_next;
            hold_cp_reg   <= hold_cp_next;
        end
    end

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
            (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite) else $error("output overwritten");

    property p_idle_ready;
        @(posedge clk) disable iff (!rst_n) s_axis_tready |-> (st_reg == S_IDLE);
    endproperty
    a_idle_ready: assert property (p_idle_ready) else $error("ready while busy");

    property p_count;
        @(posedge clk) disable iff (!rst_n) n_reg <= OutW'(MaxOut);
    endproperty
    a_count: assert property (p_count) else $error("too many results");
endmodule

// File: dv/cjk_numeral_formatter_tb.sv
// Self-checking bench for cjk_numeral_formatter: spells values in every style and
// checks each code point against a built-in spelling model. Depends on cjknf_pkg.
`timescale 1ns / 1ps
module cjk_numeral_formatter_tb;
    import cjknf_pkg::*;

    typedef struct packed {
        logic [15:0] cp;
        logic        last;
    } glyph_t;

    typedef struct {
        logic [31:0] value;
        int          n_exp;     // 0: use the spelling model
        logic [15:0] cp0;
    } vec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    glyph_t      glyphs_due[$];
    logic [2:0]  cur_style;
    int          errors = 0;
    int          stall_mode = 0;
    vec_t        dir_tab[$];

    always #10 clk = ~clk;

    cjk_numeral_formatter u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    function automatic logic [15:0] digit_glyph(input int s, input int d);
        logic [15:0] t [6][10] = '{
            '{16'h96F6, 16'h4E00, 16'h4E8C, 16'h4E09, 16'h56DB, 16'h4E94, 16'h516D,
              16'h4E03, 16'h516B, 16'h4E5D},
            '{16'h96F6, 16'h58F9, 16'h8D30, 16'h53C1, 16'h8086, 16'h4F0D, 16'h9646,
              16'h67D2, 16'h634C, 16'h7396},
            '{16'h96F6, 16'h4E00, 16'h4E8C, 16'h4E09, 16'h56DB, 16'h4E94, 16'h516D,
              16'h4E03, 16'h516B, 16'h4E5D},
            '{16'h96F6, 16'h58F9, 16'h8CB3, 16'h53C3, 16'h8086, 16'h4F0D, 16'h9678,
              16'h67D2, 16'h634C, 16'h7396},
            '{16'h3007, 16'h4E00, 16'h4E8C, 16'h4E09, 16'h56DB, 16'h4E94, 16'h516D,
              16'h4E03, 16'h516B, 16'h4E5D},
            '{16'h96F6, 16'h58F1, 16'h5F10, 16'h53C2, 16'h56DB, 16'h4F0D, 16'h516D,
              16'h4E03, 16'h516B, 16'h4E5D}};
        return t[s][d];
    endfunction

    function automatic logic [15:0] place_glyph(input int s, input int p);
        logic [15:0] t [6][3] = '{
            '{16'h5341, 16'h767E, 16'h5343}, '{16'h62FE, 16'h4F70, 16'h4EDF},
            '{16'h5341, 16'h767E, 16'h5343}, '{16'h62FE, 16'h4F70, 16'h4EDF},
            '{16'h5341, 16'h767E, 16'h5343}, '{16'h62FE, 16'h767E, 16'h9621}};
        return t[s][p];
    endfunction

    function automatic logic [15:0] group_glyph(input int s, input int g);
        logic [15:0] t [6][3] = '{
            '{16'h4E07, 16'h4EBF, 16'h4E07}, '{16'h4E07, 16'h4EBF, 16'h4E07},
            '{16'h842C, 16'h5104, 16'h5146}, '{16'h842C, 16'h5104, 16'h5146},
            '{16'h4E07, 16'h5104, 16'h5146}, '{16'h842C, 16'h5104, 16'h5146}};
        return t[s][g];
    endfunction

    task automatic emit(inout glyph_t q[$], input logic [15:0] cp);
        if (q.size() < MaxOut)
            q.push_back('{cp: cp, last: 1'b0});
    endtask

    // Spell one value in the current style and queue its code points.
    task automatic spell_value(input logic [31:0] val);
        int s, ng, nd;
        bit chinese, cn_inf, jp, jp_inf, drop, trailing;
        longint unsigned v, cap;
        int grp [4];
        int d [4];
        glyph_t q[$];
        s = (cur_style <= 5) ? int'(cur_style) : 0;
        chinese = s <= 3;
        cn_inf = (s == 0 || s == 2);
        jp = s >= 4;
        jp_inf = (s == 4);
        cap = 1;
        for (int i = 0; i < MaxGroups && i < 4; i++)
            cap = cap * 10000;
        cap = cap - 1;
        v = val;
        if (v > cap)
            v = cap;
        if (v == 0)
        begin
            glyphs_due.push_back('{cp: digit_glyph(s, 0), last: 1'b1});
            return;
        end
        ng = 0;
        grp = '{0, 0, 0, 0};
        while (v > 0 && ng < 4)
        begin
            grp[ng] = int'(v % 10000);
            v = v / 10000;
            ng++;
        end
        for (int g = ng - 1; g >= 0; g--)
        begin
            for (int i = 0; i < 4; i++)
                d[i] = (grp[g] / (10 ** i)) % 10;
            nd = 4;
            if (g == ng - 1)
            begin
                nd = 0;
                for (int i = 0; i < 4; i++)
                    if (d[i] != 0)
                        nd = i + 1;
            end
            for (int i = nd - 1; i >= 0; i--)
            begin
                drop = 0;
                if (cn_inf && grp[g] >= 10 && grp[g] < 20 && i == 1)
                    drop = 1;
                if (jp_inf && d[i] == 1 && i != 0)
                    drop = 1;
                if (jp && d[i] == 0)
                    drop = 1;
                if (chinese)
                begin
                    trailing = 1;
                    for (int k = i; k >= 0; k--)
                        if (d[k] != 0)
                            trailing = 0;
                    if (trailing)
                        drop = 1;
                    if (d[i] == 0 && i != 3 && d[i + 1] == 0)
                        drop = 1;
                end
                if (!drop)
                    emit(q, digit_glyph(s, d[i]));
                if (d[i] != 0 && i != 0)
                    emit(q, place_glyph(s, i - 1));
            end
            if (grp[g] != 0 && g != 0)
            begin
                emit(q, group_glyph(s, g - 1));
                if (g == 3 && s <= 1)
                    emit(q, 16'h4EBF);
            end
        end
        q[q.size() - 1].last = 1'b1;
        foreach (q[i])
            glyphs_due.push_back(q[i]);
    endtask

    task automatic write_style(input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_style = val[2:0];
    endtask

    // One request; gaps only between bursts.
    task automatic send_value(input logic [31:0] val, input bit gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        do @(posedge clk); while (!s_axis_tready);
        spell_value(val);
        if (gap)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (glyphs_due.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return $urandom_range(0, 20);
            1: return $urandom_range(0, 9999);
            2: return $urandom_range(0, 9) * 10000 + $urandom_range(0, 19);
            3: return $urandom_range(1, 9) * 100000000 + $urandom_range(0, 9) * 1000
                      + $urandom_range(0, 9);
            4: return $urandom;
            5: return 32'd999_999_999 + $urandom_range(0, 3);
            default: return $urandom_range(0, 999_999_999);
        endcase
    endfunction

    // Receiver: stall pattern changes per phase.
    always @(posedge clk)
    begin
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (glyphs_due.size() == 0)
            begin
                $display("%0t: unexpected code point %h last %b", $time,
                         m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                glyph_t e;
                e = glyphs_due.pop_front();
                if (e.cp !== m_axis_tdata || e.last !== m_axis_tlast)
                begin
                    $display("%0t: expected %h/%b got %h/%b", $time, e.cp, e.last,
                             m_axis_tdata, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #40ms;
        $display("[cjk_numeral_formatter] ERROR");
        $finish;
    end

    initial
    begin
        int burst;
        logic [7:0] styles [8] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd6, 8'd0};
        cur_style = STY_SIMP_INF;
        // directed: zero, extremes, teens, zero runs, saturation
        dir_tab = '{
            '{32'd0, 1, 16'h96F6}, '{32'd1, 1, 16'h4E00}, '{32'd9, 1, 16'h4E5D},
            '{32'd10, 0, 0}, '{32'd11, 0, 0}, '{32'd19, 0, 0}, '{32'd20, 0, 0},
            '{32'd101, 0, 0}, '{32'd1001, 0, 0}, '{32'd1010, 0, 0},
            '{32'd10000, 0, 0}, '{32'd10010, 0, 0}, '{32'd100_000_000, 0, 0},
            '{32'd100_000_001, 0, 0}, '{32'd111_111_111, 0, 0},
            '{32'd999_999_999, 0, 0}, '{32'd1_000_000_000, 0, 0},
            '{32'h8000_0000, 0, 0}, '{32'hFFFF_FFFF, 0, 0}, '{32'd5_0000_0005, 0, 0},
            '{32'h5555_5555, 0, 0}, '{32'hAAAA_AAAA, 0, 0}};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].n_exp != 0)
            begin
                glyphs_due.push_back('{cp: dir_tab[i].cp0, last: 1'b1});
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= dir_tab[i].value;
                do @(posedge clk); while (!s_axis_tready);
            end
            else
                send_value(dir_tab[i].value, 1'b0);
        end
        s_axis_tvalid <= 1'b0;
        drain();
        // random: each phase a new style and stall pattern
        foreach (styles[p])
        begin
            write_style(styles[p]);
            stall_mode = p % 3;
            if (styles[p] == 8'd4)
                send_value(32'd0, 1'b0);   // Japanese zero glyph
            for (int n = 0; n < 55; )
            begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst && n < 55; b++, n++)
                    send_value(rand_value(), (b == burst - 1) || n == 54);
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end
        if (glyphs_due.size() != 0)
            errors++;
        if (errors == 0)
            $display("[cjk_numeral_formatter] OK");
        else
            $display("[cjk_numeral_formatter] ERROR");
        $finish;
    end
endmodule
